[sv/pgf_pkg.sv]
// Shared constants and types for the pairwise gravity force pipeline.
// Depends on nothing; imported by the top level.
package pgf_pkg;

   localparam int MASS_W      = 32;
   localparam int GRAV_W      = 32;
   localparam int DIST_W      = 48;
   localparam int FORCE_W     = 48;
   localparam int FRAC_W      = 16;
   localparam int CHUNK_W     = 32;
   localparam int NUM_W       = GRAV_W + 2 * MASS_W;
   localparam int MAG_W       = NUM_W - FRAC_W;
   localparam int SCALE_W     = DIST_W + FRAC_W;
   localparam int PROD_W      = 128;
   localparam int QUO_W       = FORCE_W;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 48;

   localparam logic [CSR_INDEX_W-1:0] CSR_GRAV_CONSTANT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_DIST_SQ   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_DIST_SQ   = 2'd2;

   localparam logic [GRAV_W-1:0] GRAV_RESET     = 32'h0001_0000;
   localparam logic [DIST_W-1:0] MIN_DIST_RESET = 48'h0000_0001_0000;
   localparam logic [DIST_W-1:0] MAX_DIST_RESET = 48'hFFFF_FFFF_FFFF;

   localparam logic [FORCE_W-1:0] FORCE_POS_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [FORCE_W-1:0] FORCE_NEG_MAG = 48'h8000_0000_0000;

   typedef struct packed {
      logic [2:0] neg;
      logic       zero;
   } pgf_flags_type;

endpackage

[sv/pgf_delay.sv]
// Enabled shift-register delay line for pipeline side data.
// Standalone; no package dependency.
module pgf_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign dout = tap_ff[DEPTH-1];

endmodule

[sv/pgf_isqrt.sv]
// Pipelined integer square root, one result bit per register stage.
// Standalone; no package dependency.
module pgf_isqrt #(
   parameter int IN_W = 66
) (
   input  logic                clock,
   input  logic                en,
   input  logic [IN_W-1:0]     radicand,
   output logic [IN_W/2-1:0]   root
);

   localparam int OUT_W = IN_W / 2;
   localparam int RW    = OUT_W + 3;

   logic [RW-1:0]    rem_ff   [OUT_W];
   logic [RW-1:0]    rem_in   [OUT_W];
   logic [OUT_W-1:0] root_ff  [OUT_W];
   logic [OUT_W-1:0] root_in  [OUT_W];
   logic [IN_W-1:0]  src_ff   [OUT_W];
   logic [IN_W-1:0]  src_in   [OUT_W];
   logic [RW-1:0]    prem     [OUT_W];
   logic [OUT_W-1:0] proot    [OUT_W];
   logic [IN_W-1:0]  psrc     [OUT_W];
   logic [RW-1:0]    rem_sh   [OUT_W];
   logic [RW-1:0]    trial    [OUT_W];

   always_comb begin
      for (int j = 0; j < OUT_W; j++) begin
         if (j == 0) begin
            prem[j]  = '0;
            proot[j] = '0;
            psrc[j]  = radicand;
         end else begin
            prem[j]  = rem_ff[j-1];
            proot[j] = root_ff[j-1];
            psrc[j]  = src_ff[j-1];
         end
         rem_sh[j] = {prem[j][RW-3:0], psrc[j][IN_W-1 -: 2]};
         trial[j]  = RW'({proot[j], 2'b01});
         if (rem_sh[j] >= trial[j]) begin
            rem_in[j]  = rem_sh[j] - trial[j];
            root_in[j] = {proot[j][OUT_W-2:0], 1'b1};
         end else begin
            rem_in[j]  = rem_sh[j];
            root_in[j] = {proot[j][OUT_W-2:0], 1'b0};
         end
         src_in[j] = psrc[j] << 2;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < OUT_W; j++) begin
            rem_ff[j]  <= rem_in[j];
            root_ff[j] <= root_in[j];
            src_ff[j]  <= src_in[j];
         end
      end
   end

   assign root = root_ff[OUT_W-1];

endmodule

[sv/pgf_div.sv]
// Pipelined restoring divider, one quotient bit per register stage.
// Returns the low QUO_W quotient bits; standalone, no package dependency.
module pgf_div #(
   parameter int NUM_W = 96,
   parameter int DEN_W = 64,
   parameter int QUO_W = 80
) (
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic [QUO_W-1:0] quot
);

   localparam int TOP_W = NUM_W - QUO_W;

   logic [TOP_W+DEN_W-1:0] head;
   logic [DEN_W-1:0]       rem_ff  [QUO_W];
   logic [DEN_W-1:0]       rem_in  [QUO_W];
   logic [QUO_W-1:0]       quo_ff  [QUO_W];
   logic [QUO_W-1:0]       quo_in  [QUO_W];
   logic [DEN_W-1:0]       den_ff  [QUO_W];
   logic [DEN_W-1:0]       den_in  [QUO_W];
   logic [DEN_W-1:0]       prem    [QUO_W];
   logic [QUO_W-1:0]       pquo    [QUO_W];
   logic [DEN_W:0]         rem_sh  [QUO_W];
   logic [DEN_W:0]         rem_sub [QUO_W];
   logic                   take    [QUO_W];

   assign head = {{DEN_W{1'b0}}, numer[NUM_W-1:QUO_W]};

   always_comb begin
      for (int j = 0; j < QUO_W; j++) begin
         if (j == 0) begin
            prem[j]   = head[DEN_W-1:0];
            pquo[j]   = numer[QUO_W-1:0];
            den_in[j] = denom;
         end else begin
            prem[j]   = rem_ff[j-1];
            pquo[j]   = quo_ff[j-1];
            den_in[j] = den_ff[j-1];
         end
         rem_sh[j]  = {prem[j], pquo[j][QUO_W-1]};
         rem_sub[j] = rem_sh[j] - {1'b0, den_in[j]};
         take[j]    = rem_sh[j] >= {1'b0, den_in[j]};
         rem_in[j]  = take[j] ? rem_sub[j][DEN_W-1:0] : rem_sh[j][DEN_W-1:0];
         quo_in[j]  = {pquo[j][QUO_W-2:0], take[j]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < QUO_W; j++) begin
            rem_ff[j] <= rem_in[j];
            quo_ff[j] <= quo_in[j];
            den_ff[j] <= den_in[j];
         end
      end
   end

   assign quot = quo_ff[QUO_W-1];

endmodule

[sv/pairwise_gravity_force.sv]
// Pairwise gravity force: fully pipelined force unit for one body pair per transaction.
// Depends on pgf_pkg, pgf_delay, pgf_isqrt and pgf_div.
//
// Usage:
//   req_* carries one pair (two Q16.16 positions, two Q16.16 masses) per transaction;
//   rsp_* returns the Q32.16 force on the first body and a saturation flag.
//   csr_* writes grav_constant (0), min_dist_sq (1) and max_dist_sq (2); write them
//   only while no transaction is in flight.
// Pipeline: the 80-stage magnitude divider and the 48-stage per-axis divider
//   lie in series between request accept and response valid.
// Throughput: one transaction per cycle while not stalled; every stage holds one item.
// Stall: the whole pipeline freezes while rsp_valid is high and rsp_stall is high;
//   req_stall follows that condition in the same cycle, so nothing is lost.
// Reset: clears all valid bits and loads the register reset values
//   (G = 1.0, min_dist_sq = 1.0, max_dist_sq = all ones).
module pairwise_gravity_force #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [COORD_WIDTH-1:0]       req_pos_a_x,
   input  logic signed [COORD_WIDTH-1:0]       req_pos_a_y,
   input  logic signed [COORD_WIDTH-1:0]       req_pos_a_z,
   input  logic signed [COORD_WIDTH-1:0]       req_pos_b_x,
   input  logic signed [COORD_WIDTH-1:0]       req_pos_b_y,
   input  logic signed [COORD_WIDTH-1:0]       req_pos_b_z,
   input  logic [pgf_pkg::MASS_W-1:0]          req_mass_a,
   input  logic [pgf_pkg::MASS_W-1:0]          req_mass_b,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [pgf_pkg::FORCE_W-1:0]  rsp_force_x,
   output logic signed [pgf_pkg::FORCE_W-1:0]  rsp_force_y,
   output logic signed [pgf_pkg::FORCE_W-1:0]  rsp_force_z,
   output logic                                rsp_saturated,
   input  logic                                csr_write,
   input  logic [pgf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pgf_pkg::CSR_DATA_W-1:0]      csr_data
);

   import pgf_pkg::*;

   localparam int DIFF_W     = COORD_WIDTH + 1;
   localparam int SUM_W      = 2 * COORD_WIDTH + 2;
   localparam int LEN_W      = COORD_WIDTH + 1;
   localparam int STG_SUM    = 5;
   localparam int STG_D2C    = 6;
   localparam int STG_MAG    = STG_D2C + MAG_W;
   localparam int STG_PROD   = STG_MAG + 3;
   localparam int STG_QUO    = STG_PROD + QUO_W;
   localparam int PIPE_DEPTH = STG_QUO + 1;
   localparam int LEN_DLY    = STG_PROD - (STG_SUM + LEN_W);

   logic                    pipe_advance;
   logic [PIPE_DEPTH-1:0]   vld_ff;
   logic [PIPE_DEPTH-1:0]   vld_in;

   logic [GRAV_W-1:0]       grav_ff;
   logic [DIST_W-1:0]       min_dist_ff;
   logic [DIST_W-1:0]       max_dist_ff;

   logic [COORD_WIDTH-1:0]  pos_a [3];
   logic [COORD_WIDTH-1:0]  pos_b [3];

   logic [DIFF_W-1:0]       diff_ff [3];
   logic [DIFF_W-1:0]       diff_in [3];
   logic [2*MASS_W-1:0]     mab_ff;
   logic [DIFF_W-1:0]       dist_ff [3];
   logic [DIFF_W-1:0]       dist_in [3];
   logic [2:0]              neg_ff;
   logic [GRAV_W+CHUNK_W-1:0] g_lo_ff;
   logic [GRAV_W+CHUNK_W-1:0] g_hi_ff;
   logic [63:0]             dist64 [3];
   logic [63:0]             sq_ll_ff [3];
   logic [63:0]             sq_lh_ff [3];
   logic [63:0]             sq_hh_ff [3];
   logic [NUM_W-1:0]        num_ff;
   logic [SUM_W-1:0]        sq_ff [3];
   logic [SUM_W-1:0]        sum_ff;
   logic [SUM_W+DIST_W-1:0] d2_wide;
   logic [DIST_W-1:0]       d2_sat;
   logic [DIST_W-1:0]       d2c_in;
   logic [DIST_W-1:0]       d2c_ff;
   logic                    zero_ff;
   logic [NUM_W-1:0]        num_d2c;
   logic [2:0]              neg_d2c;
   pgf_flags_type           flags_ff;
   pgf_flags_type           flags_quo;

   logic [LEN_W-1:0]        len_root;
   logic [LEN_W-1:0]        len_prod;
   logic [MAG_W-1:0]        mag;
   logic [3*CHUNK_W-1:0]    mag_pad;
   logic [DIFF_W-1:0]       dist_mag [3];
   logic [63:0]             dist_mag64 [3];
   logic [63:0]             pp_ff [3][3][2];
   logic [PROD_W-1:0]       row_ff [3][2];
   logic [PROD_W-1:0]       prod_ff [3];
   logic [2:0]              ovf_in;
   logic [2:0]              ovf_quo;
   logic [QUO_W-1:0]        quo [3];

   logic [FORCE_W-1:0]      lim [3];
   logic [FORCE_W-1:0]      fmag [3];
   logic [2:0]              sat_k;
   logic [FORCE_W-1:0]      force_in [3];
   logic [FORCE_W-1:0]      force_ff [3];
   logic                    sat_ff;

   // Pipeline control
   assign pipe_advance = !(vld_ff[PIPE_DEPTH-1] && rsp_stall);
   assign req_stall    = !pipe_advance;
   assign vld_in       = {vld_ff[PIPE_DEPTH-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_advance) begin
         vld_ff <= vld_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         grav_ff     <= GRAV_RESET;
         min_dist_ff <= MIN_DIST_RESET;
         max_dist_ff <= MAX_DIST_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_GRAV_CONSTANT: grav_ff     <= csr_data[GRAV_W-1:0];
            CSR_MIN_DIST_SQ:   min_dist_ff <= csr_data[DIST_W-1:0];
            CSR_MAX_DIST_SQ:   max_dist_ff <= csr_data[DIST_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign pos_a[0] = req_pos_a_x;
   assign pos_a[1] = req_pos_a_y;
   assign pos_a[2] = req_pos_a_z;
   assign pos_b[0] = req_pos_b_x;
   assign pos_b[1] = req_pos_b_y;
   assign pos_b[2] = req_pos_b_z;

   // Stages 1 to 6: difference, magnitude, squares, sum, numerator, clamp
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         diff_in[k] = {pos_b[k][COORD_WIDTH-1], pos_b[k]}
                    - {pos_a[k][COORD_WIDTH-1], pos_a[k]};
         dist_in[k] = diff_ff[k][DIFF_W-1] ? (~diff_ff[k] + DIFF_W'(1)) : diff_ff[k];
         dist64[k]  = 64'(dist_ff[k]);
      end
   end

   assign d2_wide = {{DIST_W{1'b0}}, sum_ff} >> FRAC_W;
   assign d2_sat  = (|d2_wide[SUM_W+DIST_W-1:DIST_W]) ? MAX_DIST_RESET : d2_wide[DIST_W-1:0];

   always_comb begin
      if (d2_sat < min_dist_ff) begin
         d2c_in = min_dist_ff;
      end else if (d2_sat > max_dist_ff) begin
         d2c_in = max_dist_ff;
      end else begin
         d2c_in = d2_sat;
      end
      if (d2c_in == '0) begin
         d2c_in = DIST_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         for (int k = 0; k < 3; k++) begin
            diff_ff[k]  <= diff_in[k];
            dist_ff[k]  <= dist_in[k];
            neg_ff[k]   <= diff_ff[k][DIFF_W-1];
            sq_ll_ff[k] <= 64'(dist64[k][31:0]) * 64'(dist64[k][31:0]);
            sq_lh_ff[k] <= 64'(dist64[k][31:0]) * 64'(dist64[k][63:32]);
            sq_hh_ff[k] <= 64'(dist64[k][63:32]) * 64'(dist64[k][63:32]);
            sq_ff[k]    <= SUM_W'(130'(sq_ll_ff[k]) + (130'(sq_lh_ff[k]) << 33)
                                  + (130'(sq_hh_ff[k]) << 64));
         end
         mab_ff  <= 64'(req_mass_a) * 64'(req_mass_b);
         g_lo_ff <= 64'(grav_ff) * 64'(mab_ff[CHUNK_W-1:0]);
         g_hi_ff <= 64'(grav_ff) * 64'(mab_ff[2*CHUNK_W-1:CHUNK_W]);
         num_ff  <= NUM_W'(g_lo_ff) + (NUM_W'(g_hi_ff) << CHUNK_W);
         sum_ff  <= sq_ff[0] + sq_ff[1] + sq_ff[2];
         d2c_ff  <= d2c_in;
         zero_ff <= (sum_ff == '0);
      end
   end

   pgf_delay #(.WIDTH(NUM_W), .DEPTH(STG_D2C - 3)) u_num_dly (
      .clock (clock),
      .en    (pipe_advance),
      .din   (num_ff),
      .dout  (num_d2c)
   );

   pgf_delay #(.WIDTH(3), .DEPTH(STG_D2C - 2)) u_neg_dly (
      .clock (clock),
      .en    (pipe_advance),
      .din   (neg_ff),
      .dout  (neg_d2c)
   );

   assign flags_ff.neg  = neg_d2c;
   assign flags_ff.zero = zero_ff;

   pgf_delay #(.WIDTH($bits(pgf_flags_type)), .DEPTH(STG_QUO - STG_D2C)) u_flag_dly (
      .clock (clock),
      .en    (pipe_advance),
      .din   (flags_ff),
      .dout  (flags_quo)
   );

   // Length and force magnitude
   pgf_isqrt #(.IN_W(SUM_W)) u_isqrt (
      .clock    (clock),
      .en       (pipe_advance),
      .radicand (sum_ff),
      .root     (len_root)
   );

   pgf_delay #(.WIDTH(LEN_W), .DEPTH(LEN_DLY)) u_len_dly (
      .clock (clock),
      .en    (pipe_advance),
      .din   (len_root),
      .dout  (len_prod)
   );

   pgf_div #(.NUM_W(NUM_W), .DEN_W(SCALE_W), .QUO_W(MAG_W)) u_mag_div (
      .clock (clock),
      .en    (pipe_advance),
      .numer (num_d2c),
      .denom ({d2c_ff, {FRAC_W{1'b0}}}),
      .quot  (mag)
   );

   assign mag_pad = (3*CHUNK_W)'(mag);

   // Per-axis product and division by length
   generate
      for (genvar k = 0; k < 3; k++) begin : g_axis
         pgf_delay #(.WIDTH(DIFF_W), .DEPTH(STG_MAG - 2)) u_dist_dly (
            .clock (clock),
            .en    (pipe_advance),
            .din   (dist_ff[k]),
            .dout  (dist_mag[k])
         );

         pgf_div #(.NUM_W(PROD_W), .DEN_W(LEN_W), .QUO_W(QUO_W)) u_axis_div (
            .clock (clock),
            .en    (pipe_advance),
            .numer (prod_ff[k]),
            .denom (len_prod),
            .quot  (quo[k])
         );
      end
   endgenerate

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         dist_mag64[k] = 64'(dist_mag[k]);
         ovf_in[k]     = prod_ff[k][PROD_W-1:QUO_W] >= (PROD_W-QUO_W)'(len_prod);
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
               for (int j = 0; j < 2; j++) begin
                  pp_ff[k][i][j] <= 64'(mag_pad[i*CHUNK_W +: CHUNK_W])
                                  * 64'(dist_mag64[k][j*CHUNK_W +: CHUNK_W]);
               end
            end
            for (int j = 0; j < 2; j++) begin
               row_ff[k][j] <= PROD_W'(pp_ff[k][0][j])
                             + (PROD_W'(pp_ff[k][1][j]) << CHUNK_W)
                             + (PROD_W'(pp_ff[k][2][j]) << (2*CHUNK_W));
            end
            prod_ff[k] <= row_ff[k][0] + (row_ff[k][1] << CHUNK_W);
         end
      end
   end

   pgf_delay #(.WIDTH(3), .DEPTH(QUO_W)) u_ovf_dly (
      .clock (clock),
      .en    (pipe_advance),
      .din   (ovf_in),
      .dout  (ovf_quo)
   );

   // Saturate, apply sign, drop everything for coincident bodies
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         lim[k] = flags_quo.neg[k] ? FORCE_NEG_MAG : FORCE_POS_MAX;
         if (flags_quo.zero) begin
            fmag[k]  = '0;
            sat_k[k] = 1'b0;
         end else if (ovf_quo[k] || quo[k] > lim[k]) begin
            fmag[k]  = lim[k];
            sat_k[k] = 1'b1;
         end else begin
            fmag[k]  = quo[k];
            sat_k[k] = 1'b0;
         end
         force_in[k] = flags_quo.neg[k] ? (~fmag[k] + FORCE_W'(1)) : fmag[k];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_advance) begin
         for (int k = 0; k < 3; k++) begin
            force_ff[k] <= force_in[k];
         end
         sat_ff <= |sat_k;
      end
   end

   assign rsp_valid     = vld_ff[PIPE_DEPTH-1];
   assign rsp_force_x   = force_ff[0];
   assign rsp_force_y   = force_ff[1];
   assign rsp_force_z   = force_ff[2];
   assign rsp_saturated = sat_ff;

`ifndef SYNTHESIS
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !pipe_advance |=> vld_ff == $past(vld_ff))
      else $error("valid pipeline moved during a stall");

   a_d2c_nonzero: assert property (@(posedge clock) disable iff (reset)
      vld_ff[STG_D2C-1] |-> d2c_ff != '0)
      else $error("clamped squared distance is zero");

   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         (force_ff[0] == FORCE_POS_MAX || force_ff[0] == FORCE_NEG_MAG ||
          force_ff[1] == FORCE_POS_MAX || force_ff[1] == FORCE_NEG_MAG ||
          force_ff[2] == FORCE_POS_MAX || force_ff[2] == FORCE_NEG_MAG))
      else $error("saturation flagged without a limit value");
`endif

endmodule

[test/tb_pairwise_gravity_force.sv]
// Testbench for pairwise_gravity_force: random and corner-case body pairs under
// several register settings and idle/stall mixes, checked against an in-bench predictor.
// Depends on pgf_pkg and the pairwise_gravity_force RTL.
module tb_pairwise_gravity_force;
   timeunit 1ns;
   timeprecision 1ps;
   import pgf_pkg::*;

   typedef struct {
      logic signed [FORCE_W-1:0] fx, fy, fz;
      logic                      sat;
   } force_type;

   class force_scoreboard;
      force_type pending[$];
      bit [GRAV_W-1:0] grav;
      bit [DIST_W-1:0] dmin, dmax;
      int errors, checked;

      function new();
         grav = GRAV_RESET; dmin = MIN_DIST_RESET; dmax = MAX_DIST_RESET;
      endfunction

      function void set_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
         case (idx)
            CSR_GRAV_CONSTANT: grav = v[GRAV_W-1:0];
            CSR_MIN_DIST_SQ: dmin = v;
            CSR_MAX_DIST_SQ: dmax = v;
            default: ;
         endcase
      endfunction

      function void note_pair(logic signed [31:0] ax, ay, az, bx, by, bz,
                              logic [31:0] ma, mb);
         bit signed [33:0] d[3];
         bit [32:0] m[3];
         bit [127:0] s, t, num, mag, c, r, tt;
         bit [47:0] d2;
         bit [63:0] len, lim;
         force_type f;
         d[0] = 34'(bx) - 34'(ax);
         d[1] = 34'(by) - 34'(ay);
         d[2] = 34'(bz) - 34'(az);
         s = 0;
         for (int k = 0; k < 3; k++) begin
            m[k] = 33'(d[k] < 0 ? -d[k] : d[k]);
            s += 128'(m[k]) * 128'(m[k]);
         end
         f = '{0, 0, 0, 0};
         if (s != 0) begin
            t = s >> 16;
            d2 = (t > 128'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : t[47:0];
            if (d2 < dmin) d2 = dmin;
            else if (d2 > dmax) d2 = dmax;
            if (d2 == 0) d2 = 1;
            r = 0;
            for (int b = 49; b >= 0; b--) begin
               tt = r | (128'd1 << b);
               if (tt * tt <= s) r = tt;
            end
            len = r[63:0];
            num = 128'(grav) * 128'(ma) * 128'(mb);
            mag = (num / 128'(d2)) >> 16;
            for (int k = 0; k < 3; k++) begin
               c = (mag * 128'(m[k])) / 128'(len);
               lim = d[k] < 0 ? 64'h8000_0000_0000 : 64'h7FFF_FFFF_FFFF;
               if (c > 128'(lim)) begin
                  c = 128'(lim); f.sat = 1;
               end
               if (d[k] < 0) c = -c;
               if (k == 0) f.fx = c[47:0];
               else if (k == 1) f.fy = c[47:0];
               else f.fz = c[47:0];
            end
         end
         pending.push_back(f);
      endfunction

      function void check_force(force_type got);
         force_type e;
         checked++;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected result fx=%h", $time, got.fx);
            return;
         end
         e = pending.pop_front();
         if (got.fx !== e.fx) begin
            errors++; $display("%0t: force_x exp %h got %h", $time, e.fx, got.fx);
         end
         if (got.fy !== e.fy) begin
            errors++; $display("%0t: force_y exp %h got %h", $time, e.fy, got.fy);
         end
         if (got.fz !== e.fz) begin
            errors++; $display("%0t: force_z exp %h got %h", $time, e.fz, got.fz);
         end
         if (got.sat !== e.sat) begin
            errors++; $display("%0t: saturated exp %b got %b", $time, e.sat, got.sat);
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_stall = 0, csr_write = 0;
   logic req_stall, rsp_valid, rsp_saturated;
   logic signed [31:0] ax = 0, ay = 0, az = 0, bx = 0, by = 0, bz = 0;
   logic [31:0] ma = 0, mb = 0;
   logic signed [FORCE_W-1:0] rsp_force_x, rsp_force_y, rsp_force_z;
   logic [CSR_INDEX_W-1:0] csr_index = 0;
   logic [CSR_DATA_W-1:0] csr_data = 0;
   int send_idle = 0, recv_stall = 0, quiet = 0, sent = 0;
   force_scoreboard sb = new();

   pairwise_gravity_force dut (
      .clock, .reset, .req_valid, .req_stall,
      .req_pos_a_x(ax), .req_pos_a_y(ay), .req_pos_a_z(az),
      .req_pos_b_x(bx), .req_pos_b_y(by), .req_pos_b_z(bz),
      .req_mass_a(ma), .req_mass_b(mb),
      .rsp_valid, .rsp_stall, .rsp_force_x, .rsp_force_y, .rsp_force_z, .rsp_saturated,
      .csr_write, .csr_index, .csr_data);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_force('{rsp_force_x, rsp_force_y, rsp_force_z, rsp_saturated});
      if (!reset && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))) quiet <= 0;
      else quiet <= quiet + 1;
      rsp_stall <= ($urandom_range(99) < recv_stall);
      if (quiet > 20000) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(5))
         0: return $urandom;
         1: return 32'h8000_0000 ^ $urandom_range(3);
         2: return 32'h7FFF_FFFF - $urandom_range(3);
         default: return $signed(16'($urandom)) <<< $urandom_range(16);
      endcase
   endfunction

   function automatic logic [31:0] rand_mass();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'hFFFF_FFFF;
         default: return $urandom_range(32'h0010_0000);
      endcase
   endfunction

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
      csr_write <= 1; csr_index <= idx; csr_data <= v;
      sb.set_reg(idx, v);
      @(posedge clock);
      csr_write <= 0;
   endtask

   task automatic send_pair(logic [31:0] pax, pay, paz, pbx, pby, pbz, pma, pmb);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      ax <= pax; ay <= pay; az <= paz; bx <= pbx; by <= pby; bz <= pbz;
      ma <= pma; mb <= pmb;
      sb.note_pair(pax, pay, paz, pbx, pby, pbz, pma, pmb);
      sent++;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
   endtask

   task automatic random_pairs(int n);
      for (int i = 0; i < n; i++)
         send_pair(rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                   rand_coord(), rand_mass(), rand_mass());
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_pair(0, 0, 0, 0, 0, 0, '1, '1);
      send_pair(5, -7, 9, 5, -7, 9, 32'h10000, 32'h10000);
      send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, '1);
      send_pair(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0, '1, '1);
      send_pair(0, 0, 0, 0, 32'h10000, 0, 32'h10000, 32'h10000);
      send_pair(0, 0, 0, 1, -1, 1, '1, '1);
      send_pair(0, 0, 0, 32'h30000, 32'h40000, 0, 0, '1);
      send_pair(-3, 4, 0, 0, 0, 0, '1, 32'h1);
      random_pairs(150);
      drain();
      write_reg(CSR_GRAV_CONSTANT, 48'hFFFF_FFFF);
      write_reg(CSR_MIN_DIST_SQ, CSR_DATA_W'(0));
      write_reg(CSR_MAX_DIST_SQ, 48'h1_0000_0000);
      send_pair(0, 0, 0, 0, 0, 1, '1, '1);
      send_pair(0, 0, 0, 32'h8000_0000, 0, 0, '1, '1);
      send_pair(0, 0, 0, 0, 0, 0, '1, '1);
      send_pair(0, 0, 0, 0, 32'h7FFF_FFFF, 0, 32'h10000, 32'h10000);
      send_idle = 48;
      random_pairs(220);
      drain();
      write_reg(CSR_GRAV_CONSTANT, CSR_DATA_W'(0));
      write_reg(CSR_MIN_DIST_SQ, 48'hFFFF_FFFF_FFFF);
      write_reg(CSR_MAX_DIST_SQ, CSR_DATA_W'(1));
      send_idle = 0; recv_stall = 48;
      random_pairs(40);
      drain();
      write_reg(CSR_GRAV_CONSTANT, 48'h0000_0000_0001);
      random_pairs(180);
      drain();
      write_reg(CSR_GRAV_CONSTANT, CSR_DATA_W'($urandom));
      write_reg(CSR_MIN_DIST_SQ, 48'h0000_0100_0000);
      write_reg(CSR_MAX_DIST_SQ, 48'h0100_0000_0000);
      send_idle = 19; recv_stall = 19;
      random_pairs(220);
      drain();
      write_reg(CSR_GRAV_CONSTANT, CSR_DATA_W'(GRAV_RESET));
      write_reg(CSR_MIN_DIST_SQ, CSR_DATA_W'(1));
      write_reg(CSR_MAX_DIST_SQ, MAX_DIST_RESET);
      send_idle = 0; recv_stall = 0;
      random_pairs(230);
      drain();
      $display("Covered %0d pairs, %0d results checked, across five register settings",
               sent, sb.checked);
      $display("and four idle/stall mixes including extreme clamp bounds.");
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
